// ----- src/wacs_pkg.sv -----
// Shared types and constants for the RIFF/WEBP animation chunk scanner.
package wacs_pkg;

  localparam int unsigned CHUNK_END_W = 34;
  localparam int unsigned DECL_END_W  = 33;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WEBP = 32'h5745_4250;
  localparam logic [31:0] TAG_ANMF = 32'h414E_4D46;

  localparam logic [3:0] HDR_POS_RIFF = 4'd3;
  localparam logic [3:0] HDR_SIZE_LO  = 4'd4;
  localparam logic [3:0] HDR_POS_SIZE = 4'd7;
  localparam logic [3:0] HDR_TAG2_LO  = 4'd8;
  localparam logic [3:0] HDR_POS_WEBP = 4'd11;

  localparam logic [2:0] CHK_TAG_BYTES = 3'd4;
  localparam logic [2:0] CHK_LAST_BYTE = 3'd7;

  localparam logic [CHUNK_END_W-1:0] CHK_HDR_LEN = 34'd8;
  localparam logic [CHUNK_END_W-1:0] FIRST_CHUNK = 34'd12;
  localparam logic [DECL_END_W-1:0]  RIFF_HDR_LEN = 33'd8;

  localparam logic [1:0] FRAMES_MAX = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CHUNK  = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_NOT_ANIM = 3'd0,
    ST_ANIM     = 3'd1,
    ST_BAD_HDR  = 3'd2,
    ST_SIZE     = 3'd3,
    ST_OVERRUN  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0] frames_seen;
    status_t    status;
    logic       animated;
  } result_t;

endpackage

// ----- src/wacs_in_reg.sv -----
// Input register stage holding one accepted byte transaction.
module wacs_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  wacs_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output wacs_pkg::item_t item
);
  import wacs_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

// ----- src/wacs_walker.sv -----
// Header check and chunk walk state, stepped once per byte.
module wacs_walker #(
  parameter int unsigned POSITION_BITS = 34
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  wacs_pkg::item_t   item,
  output logic              res_valid,
  output wacs_pkg::result_t result
);
  import wacs_pkg::*;

  localparam int unsigned CMP_W = POSITION_BITS + 1;

  phase_t                   phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [DECL_END_W-1:0]    decl_end_r, decl_end_nxt;
  logic [31:0]              word_r, word_nxt;
  logic [31:0]              tag_r, tag_nxt;
  logic [CHUNK_END_W-1:0]   chunk_end_r, chunk_end_nxt;
  logic [2:0]               idx_r, idx_nxt;
  logic [1:0]               fc_r, fc_nxt;
  status_t                  outcome_r, outcome_nxt;

  logic [31:0]              word_in;
  logic [31:0]              tag_in;
  logic [3:0]               hpos;
  logic [CHUNK_END_W-1:0]   ce_plus8;
  logic [CHUNK_END_W-1:0]   decl_ext;
  logic                     walk_ok;
  logic [32:0]              padded;
  logic [CHUNK_END_W-1:0]   next_end;
  logic                     pos_at_end;
  logic [1:0]               fc_inc;
  logic                     is_anmf;

  assign word_in    = {item.data_byte, word_r[31:8]};
  assign tag_in     = {tag_r[23:0], item.data_byte};
  assign hpos       = pos_r[3:0];
  assign decl_ext   = CHUNK_END_W'(decl_end_r);
  assign ce_plus8   = chunk_end_r + CHK_HDR_LEN;
  assign walk_ok    = ce_plus8 <= decl_ext;
  assign padded     = {1'b0, word_in} + {32'd0, word_in[0]};
  assign next_end   = chunk_end_r + CHUNK_END_W'(padded);
  assign pos_at_end = ({1'b0, pos_r} + CMP_W'(1)) == CMP_W'(chunk_end_r);
  assign fc_inc     = (fc_r < FRAMES_MAX) ? fc_r + 2'd1 : fc_r;
  assign is_anmf    = tag_r == TAG_ANMF;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    decl_end_nxt  = decl_end_r;
    word_nxt      = word_r;
    tag_nxt       = tag_r;
    chunk_end_nxt = chunk_end_r;
    idx_nxt       = idx_r;
    fc_nxt        = fc_r;
    outcome_nxt   = outcome_r;
    res_valid     = 1'b0;
    result        = '0;

    if (step) begin
      pos_nxt = (pos_r != '1) ? pos_r + POSITION_BITS'(1) : pos_r;
      unique case (phase_r)
        PH_HEADER: begin
          if (hpos < HDR_SIZE_LO || hpos >= HDR_TAG2_LO) begin
            tag_nxt = tag_in;
          end else begin
            word_nxt = word_in;
          end
          priority if (hpos == HDR_POS_RIFF && tag_in != TAG_RIFF) begin
            outcome_nxt = ST_BAD_HDR;
            phase_nxt   = PH_DONE;
          end else if (hpos == HDR_POS_SIZE) begin
            decl_end_nxt = {1'b0, word_in} + RIFF_HDR_LEN;
          end else if (hpos == HDR_POS_WEBP) begin
            priority if (tag_in != TAG_WEBP) begin
              outcome_nxt = ST_BAD_HDR;
              phase_nxt   = PH_DONE;
            end else if (FIRST_CHUNK + CHK_HDR_LEN <= decl_ext) begin
              chunk_end_nxt = FIRST_CHUNK + CHK_HDR_LEN;
              idx_nxt       = '0;
              phase_nxt     = PH_CHUNK;
            end else begin
              outcome_nxt = ST_NOT_ANIM;
              phase_nxt   = PH_DONE;
            end
          end else begin
          end
        end
        PH_CHUNK: begin
          if (idx_r < CHK_TAG_BYTES) begin
            tag_nxt = tag_in;
          end else begin
            word_nxt = word_in;
          end
          if (idx_r == CHK_LAST_BYTE) begin
            if (next_end > decl_ext) begin
              outcome_nxt = ST_OVERRUN;
              phase_nxt   = PH_DONE;
            end else begin
              if (is_anmf) begin
                fc_nxt = fc_inc;
              end
              priority if (is_anmf && fc_inc >= FRAMES_MAX) begin
                outcome_nxt = ST_ANIM;
                phase_nxt   = PH_DONE;
              end else if (padded == '0) begin
                if (walk_ok) begin
                  chunk_end_nxt = ce_plus8;
                  idx_nxt       = '0;
                  phase_nxt     = PH_CHUNK;
                end else begin
                  outcome_nxt = ST_NOT_ANIM;
                  phase_nxt   = PH_DONE;
                end
              end else begin
                chunk_end_nxt = next_end;
                phase_nxt     = PH_SKIP;
              end
            end
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
        PH_SKIP: begin
          if (pos_at_end) begin
            if (walk_ok) begin
              chunk_end_nxt = ce_plus8;
              idx_nxt       = '0;
              phase_nxt     = PH_CHUNK;
            end else begin
              outcome_nxt = ST_NOT_ANIM;
              phase_nxt   = PH_DONE;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      if (item.last_byte) begin
        res_valid = 1'b1;
        priority if (phase_nxt == PH_HEADER || outcome_nxt == ST_BAD_HDR) begin
          result.status = ST_BAD_HDR;
        end else if (POSITION_BITS'(decl_end_nxt) > pos_nxt) begin
          result.status = ST_SIZE;
        end else begin
          result.status = outcome_nxt;
        end
        result.animated    = result.status == ST_ANIM;
        result.frames_seen = fc_nxt;

        phase_nxt     = PH_HEADER;
        pos_nxt       = '0;
        decl_end_nxt  = '0;
        word_nxt      = '0;
        tag_nxt       = '0;
        chunk_end_nxt = '0;
        idx_nxt       = '0;
        fc_nxt        = '0;
        outcome_nxt   = ST_NOT_ANIM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      pos_r       <= '0;
      decl_end_r  <= '0;
      word_r      <= '0;
      tag_r       <= '0;
      chunk_end_r <= '0;
      idx_r       <= '0;
      fc_r        <= '0;
      outcome_r   <= ST_NOT_ANIM;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      decl_end_r  <= decl_end_nxt;
      word_r      <= word_nxt;
      tag_r       <= tag_nxt;
      chunk_end_r <= chunk_end_nxt;
      idx_r       <= idx_nxt;
      fc_r        <= fc_nxt;
      outcome_r   <= outcome_nxt;
    end
  end

endmodule

// ----- src/wacs_out_reg.sv -----
// Result register holding one verdict until the consumer takes it.
module wacs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  wacs_pkg::result_t res,
  input  logic              out_ready,
  output logic              out_valid,
  output wacs_pkg::result_t out_res
);
  import wacs_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r, res_nxt;

  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

endmodule

// ----- src/webp_animation_chunk_scanner_unit.sv -----
// Top level: byte stream in, one animation verdict out per file.
// Path: the last byte is held in the input register, then its verdict is registered in the result register.
// Throughput: one byte per cycle; the walker steps once per byte held in the
// input register and stalls only when a verdict is due and the result register
// is still full.
// Reset: synchronous, active low; clears both stages and all walk state.
module webp_animation_chunk_scanner_unit #(
  parameter int unsigned POSITION_BITS = 34
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] animated, [3:1] status, [5:4] frames_seen
);
  import wacs_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    step;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  assign step = item_valid && (!item.last_byte || !out_tvalid || out_tready);

  wacs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  wacs_walker #(
    .POSITION_BITS (POSITION_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .result    (res)
  );

  wacs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_res   (out_res)
  );

  assign out_tdata = {2'b00, out_res};

endmodule

// ----- tb/chunk_verdict_checker.sv -----
`timescale 1ns / 1ps
// Checker: watches both channels, predicts each file's verdict and compares it.
module chunk_verdict_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,
  output int         fail_count,
  output int         pending
);
  import wacs_pkg::*;

  localparam longint unsigned OFFSET_MAX = 64'h3_FFFF_FFFF;

  phase_t            scan_phase;
  longint unsigned   offset;
  longint unsigned   decl_end;
  longint unsigned   chunk_lim;
  logic [31:0]       size_word;
  logic [31:0]       tag_word;
  logic [1:0]        anmf_cnt;
  status_t           walk_st;
  result_t           verdict_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic clear_scan();
    scan_phase = PH_HEADER;
    offset     = 0;
    decl_end   = 0;
    chunk_lim  = 0;
    size_word  = '0;
    tag_word   = '0;
    anmf_cnt   = '0;
    walk_st    = ST_NOT_ANIM;
  endtask

  // Open a chunk header at q if a whole one fits before the declared end.
  task automatic start_walk(input longint unsigned q);
    if (q + CHK_HDR_LEN <= decl_end) begin
      chunk_lim  = q + CHK_HDR_LEN;
      scan_phase = PH_CHUNK;
    end else begin
      walk_st    = ST_NOT_ANIM;
      scan_phase = PH_DONE;
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic lst);
    longint unsigned at;
    longint unsigned rel;
    longint unsigned padded;
    longint unsigned next_end;
    result_t         want;
    at = offset;
    case (scan_phase)
      PH_HEADER: begin
        if (at < HDR_SIZE_LO || at >= HDR_TAG2_LO) tag_word = {tag_word[23:0], b};
        else size_word = {b, size_word[31:8]};
        if (at == HDR_POS_RIFF && tag_word != TAG_RIFF) begin
          walk_st    = ST_BAD_HDR;
          scan_phase = PH_DONE;
        end else if (at == HDR_POS_SIZE) begin
          decl_end = {32'd0, size_word} + RIFF_HDR_LEN;
        end else if (at == HDR_POS_WEBP) begin
          if (tag_word != TAG_WEBP) begin
            walk_st    = ST_BAD_HDR;
            scan_phase = PH_DONE;
          end else begin
            start_walk(FIRST_CHUNK);
          end
        end
      end
      PH_CHUNK: begin
        rel = at - (chunk_lim - CHK_HDR_LEN);
        if (rel < CHK_TAG_BYTES) tag_word = {tag_word[23:0], b};
        else size_word = {b, size_word[31:8]};
        if (at + 1 == chunk_lim) begin
          padded   = {32'd0, size_word} + size_word[0];
          next_end = chunk_lim + padded;
          if (next_end > decl_end) begin
            walk_st    = ST_OVERRUN;
            scan_phase = PH_DONE;
          end else begin
            if (tag_word == TAG_ANMF && anmf_cnt < FRAMES_MAX) anmf_cnt = anmf_cnt + 2'd1;
            if (tag_word == TAG_ANMF && anmf_cnt >= FRAMES_MAX) begin
              walk_st    = ST_ANIM;
              scan_phase = PH_DONE;
            end else if (padded == 0) begin
              start_walk(next_end);
            end else begin
              chunk_lim  = next_end;
              scan_phase = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (at + 1 == chunk_lim) start_walk(chunk_lim);
      end
      default: ;
    endcase
    if (offset < OFFSET_MAX) offset = offset + 1;
    if (lst) begin
      if (scan_phase == PH_HEADER || walk_st == ST_BAD_HDR) want.status = ST_BAD_HDR;
      else if (decl_end > offset) want.status = ST_SIZE;
      else if (walk_st == ST_ANIM || walk_st == ST_OVERRUN) want.status = walk_st;
      else want.status = ST_NOT_ANIM;
      want.animated    = (want.status == ST_ANIM);
      want.frames_seen = anmf_cnt;
      verdict_q.push_back(want);
      clear_scan();
    end
  endtask

  task automatic check_verdict(input logic [7:0] got_byte);
    result_t want;
    result_t got;
    got = result_t'(got_byte[5:0]);
    if (verdict_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected verdict transaction: tdata=%h", got_byte);
    end else begin
      want = verdict_q.pop_front();
      if (got.animated !== want.animated || got.status !== want.status ||
          got.frames_seen !== want.frames_seen || got_byte[7:6] !== 2'b00) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("verdict mismatch: expected animated=%0d status=%0d frames=%0d",
                   want.animated, want.status, want.frames_seen);
          $display("  got animated=%0d status=%0d frames=%0d pad=%b",
                   got.animated, got.status, got.frames_seen, got_byte[7:6]);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      verdict_q.delete();
    end else begin
      if (in_tvalid && in_tready) scan_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_verdict(out_tdata);
    end
    pending <= verdict_q.size();
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the scanner testbench: builds file byte streams, drives them and reports.
module testbench;
  import wacs_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam logic [31:0] TAG_ANIM    = 32'h414E_494D;
  localparam logic [31:0] TAG_VP8X    = 32'h5650_3858;
  localparam logic [31:0] SIZE_MAX    = 32'hFFFF_FFFF;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;

  int         fail_count;
  int         pending;
  int         cycles = 0;
  int         bytes_sent = 0;
  int         files_sent = 0;
  logic [7:0] file_q[$];
  logic       calm;

  webp_animation_chunk_scanner_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  chunk_verdict_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  assign calm = (cycles >= 600 && cycles < 1100);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 32);
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (!calm && $urandom_range(99) < 32) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_file();
    int i;
    for (i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    bytes_sent += file_q.size();
    files_sent++;
    file_q.delete();
  endtask

  task automatic put_tag(input logic [31:0] t);
    file_q.push_back(t[31:24]);
    file_q.push_back(t[23:16]);
    file_q.push_back(t[15:8]);
    file_q.push_back(t[7:0]);
  endtask

  task automatic put_word(input logic [31:0] w);
    file_q.push_back(w[7:0]);
    file_q.push_back(w[15:8]);
    file_q.push_back(w[23:16]);
    file_q.push_back(w[31:24]);
  endtask

  task automatic put_header(input logic [31:0] sz);
    put_tag(TAG_RIFF);
    put_word(sz);
    put_tag(TAG_WEBP);
  endtask

  // Sizes of 64 or more get at most six payload bytes, far fewer than the size declares.
  task automatic put_chunk(input logic [31:0] tag, input logic [31:0] sz);
    put_tag(tag);
    put_word(sz);
    if (sz < 64) repeat (sz + sz[0]) file_q.push_back(8'($urandom));
    else repeat ($urandom_range(0, 6)) file_q.push_back(8'($urandom));
  endtask

  task automatic set_size(input logic [31:0] w);
    file_q[4] = w[7:0];
    file_q[5] = w[15:8];
    file_q[6] = w[23:16];
    file_q[7] = w[31:24];
  endtask

  function automatic logic [31:0] pick_tag();
    int r;
    r = $urandom_range(99);
    if (r < 50) return TAG_ANMF;
    else if (r < 65) return TAG_ANIM;
    else if (r < 80) return TAG_VP8X;
    else return $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    if ($urandom_range(99) < 8) return $urandom;
    else return $urandom_range(0, 7);
  endfunction

  task automatic make_random_file();
    int kind;
    int r;
    int cut;
    int idx;
    kind = $urandom_range(99);
    if (kind < 18) begin
      if ($urandom_range(3) == 0) put_tag(TAG_RIFF);
      repeat ($urandom_range(1, 16)) file_q.push_back(8'($urandom));
    end else begin
      put_header(32'd0);
      repeat ($urandom_range(0, 4)) put_chunk(pick_tag(), pick_size());
      r = $urandom_range(99);
      if (r < 65) set_size(file_q.size() - 8);
      else if (r < 78) set_size($urandom_range(0, file_q.size() - 8));
      else if (r < 90) set_size(file_q.size() - 8 + $urandom_range(1, 6));
      else set_size($urandom);
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 9)) file_q.push_back(8'($urandom));
      if (kind < 26) begin
        cut = $urandom_range(1, file_q.size());
        while (file_q.size() > cut) void'(file_q.pop_back());
      end else if (kind < 34) begin
        idx = $urandom_range(0, file_q.size() - 1);
        file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone byte, then a header cut one byte short
    file_q.push_back(8'hFF);
    send_file();
    put_header(32'd100);
    void'(file_q.pop_back());
    send_file();

    // bad first tag, bad form tag
    put_tag(TAG_RIFF ^ 32'h1);
    put_word(32'd12);
    put_tag(TAG_WEBP);
    put_chunk(TAG_ANMF, 32'd0);
    send_file();
    put_tag(TAG_RIFF);
    put_word(32'd4);
    put_tag(TAG_WEBP ^ 32'h0100_0000);
    send_file();

    // declared end far beyond the file; empty body
    put_header(SIZE_MAX);
    send_file();
    put_header(32'd0);
    send_file();

    // two empty frames, then trailing bytes past the declared end
    put_header(32'd0);
    put_chunk(TAG_ANMF, 32'd0);
    put_chunk(TAG_ANMF, 32'd0);
    set_size(file_q.size() - 8);
    repeat (3) file_q.push_back(8'h00);
    send_file();

    // odd payload padding with an empty chunk between frames
    put_header(32'd0);
    put_chunk(TAG_ANMF, 32'd3);
    put_chunk(TAG_VP8X, 32'd0);
    put_chunk(TAG_ANMF, 32'd1);
    set_size(file_q.size() - 8);
    send_file();

    // a single frame
    put_header(32'd0);
    put_chunk(TAG_ANIM, 32'd6);
    put_chunk(TAG_ANMF, 32'd2);
    set_size(file_q.size() - 8);
    send_file();

    // frame chunk running past the end before any frame
    put_header(32'd0);
    put_chunk(TAG_ANMF, SIZE_MAX);
    set_size(file_q.size() - 8);
    send_file();

    // overrun after one frame
    put_header(32'd0);
    put_chunk(TAG_ANMF, 32'd0);
    put_chunk(TAG_VP8X, 32'd5);
    set_size(file_q.size() - 10);
    send_file();

    // tail shorter than a chunk header
    put_header(32'd0);
    put_chunk(TAG_ANMF, 32'd0);
    repeat (5) file_q.push_back(8'hFF);
    set_size(file_q.size() - 8);
    send_file();

    // declared end covers one frame only; later frames ignored
    put_header(32'd12);
    put_chunk(TAG_ANMF, 32'd0);
    put_chunk(TAG_ANMF, 32'd0);
    put_chunk(TAG_ANMF, 32'd0);
    send_file();

    // declared end one byte past the file
    put_header(32'd0);
    put_chunk(TAG_VP8X, 32'd2);
    set_size(file_q.size() - 7);
    send_file();

    while (bytes_sent < 950 || files_sent < 40) begin
      make_random_file();
      send_file();
    end
    in_tvalid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
